@@ rtl/brm_pkg.sv @@
package brm_pkg;

	localparam int NUM_REGS    = 16;
	localparam int PROG_BYTES  = 32;
	localparam int REG_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] OPC_MOV  = 8'h03;
	localparam logic [7:0] OPC_LDC  = 8'h04;
	localparam logic [7:0] OPC_SHL  = 8'h05;
	localparam logic [7:0] OPC_SHR  = 8'h06;
	localparam logic [7:0] OPC_JMP  = 8'h07;
	localparam logic [7:0] OPC_JEND = 8'h0A;
	localparam logic [7:0] OPC_HALT = 8'h0B;
	localparam logic [7:0] OPC_ADD  = 8'h0C;
	localparam logic [7:0] OPC_SUB  = 8'h0D;
	localparam logic [7:0] OPC_XOR  = 8'h0E;
	localparam logic [7:0] OPC_OR   = 8'h0F;
	localparam logic [7:0] OPC_IN   = 8'h10;
	localparam logic [7:0] OPC_OUT  = 8'h11;

	localparam logic [7:0]        PROG_LAST_U = 8'(PROG_BYTES - 1);
	localparam logic signed [7:0] PROG_LAST   = 8'(PROG_BYTES - 1);
	localparam logic signed [9:0] PROG_LAST_W = 10'(PROG_BYTES - 1);
	localparam logic signed [9:0] WRAP_SUB    = 10'(PROG_BYTES + 2);
	localparam logic signed [9:0] PC_STEP     = 10'sd2;

	typedef enum logic [3:0] {
		CLS_NOP,
		CLS_MOV,
		CLS_LDC,
		CLS_SHL,
		CLS_SHR,
		CLS_JMP,
		CLS_HALT,
		CLS_ADD,
		CLS_SUB,
		CLS_XOR,
		CLS_OR,
		CLS_IN,
		CLS_OUT
	} op_cls_t;

	typedef logic [REG_W-1:0] reg_idx_t;

	typedef struct packed {
		op_cls_t           cls;
		reg_idx_t          rx;
		reg_idx_t          ry;
		logic [7:0]        imm;
		logic signed [7:0] off;
	} dec_t;

	typedef struct packed {
		logic signed [7:0] next_pc;
		logic              out_valid;
		logic [7:0]        out_byte;
		logic              halted;
		logic              pc_fault;
	} res_t;

	// nibble modulo register count, by repeated subtract
	function automatic reg_idx_t reg_index(input logic [3:0] nib);
		logic [4:0] r;
		r = {1'b0, nib};
		for (int k = 0; k < 8; k++) begin
			if (r >= 5'(NUM_REGS))
				r = r - 5'(NUM_REGS);
		end
		return r[REG_W-1:0];
	endfunction

endpackage

@@ rtl/brm_ram.sv @@
module brm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ rtl/brm_queue.sv @@
module brm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brm_pkg::dec_t din,
	output logic          full,
	input  logic          pop,
	output brm_pkg::dec_t dout,
	output logic          valid
);
	import brm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	dec_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign dout    = entry_q[head_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[tail_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				tail_q <= (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			if (do_pop)
				head_q <= (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/brm_front.sv @@
module brm_front (
	input  logic          push,
	output logic          full,
	input  logic [7:0]    op,
	input  logic [7:0]    operand,
	input  logic [7:0]    input_byte,
	input  logic          input_at_end,
	input  logic          q_full,
	output logic          q_push,
	output brm_pkg::dec_t q_din
);
	import brm_pkg::*;

	dec_t d;

	assign full   = q_full;
	assign q_push = push && !q_full;
	assign q_din  = d;

	always_comb begin
		d     = '0;
		d.cls = CLS_NOP;
		d.rx  = reg_index(operand[3:0]);
		d.ry  = reg_index(operand[7:4]);
		d.imm = operand;
		d.off = '0;
		case (op)
			OPC_MOV:  d.cls = CLS_MOV;
			OPC_LDC: begin
				d.cls = CLS_LDC;
				d.rx  = reg_index(4'd0);
			end
			OPC_SHL:  d.cls = CLS_SHL;
			OPC_SHR:  d.cls = CLS_SHR;
			OPC_JMP: begin
				// large unsigned offset only adds its low nibble
				d.cls = CLS_JMP;
				d.off = (operand > PROG_LAST_U) ? {4'b0, operand[3:0]} : operand;
			end
			OPC_JEND: begin
				if (input_at_end) begin
					d.cls = CLS_JMP;
					d.off = ($signed(operand) > PROG_LAST) ? {4'b0, operand[3:0]} : operand;
				end
			end
			OPC_HALT: d.cls = CLS_HALT;
			OPC_ADD:  d.cls = CLS_ADD;
			OPC_SUB:  d.cls = CLS_SUB;
			OPC_XOR:  d.cls = CLS_XOR;
			OPC_OR:   d.cls = CLS_OR;
			OPC_IN: begin
				d.cls = CLS_IN;
				d.imm = input_byte;
			end
			OPC_OUT:  d.cls = CLS_OUT;
			default:  d.cls = CLS_NOP;
		endcase
	end

endmodule

@@ rtl/brm_back.sv @@
module brm_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  brm_pkg::dec_t            q_dout,
	output logic                     q_pop,
	output logic                     ram_we,
	output brm_pkg::reg_idx_t        ram_waddr,
	output logic [7:0]               ram_wdata,
	output logic                     ram_re,
	output brm_pkg::reg_idx_t        ram_raddr_a,
	output brm_pkg::reg_idx_t        ram_raddr_b,
	input  logic [7:0]               ram_rdata_a,
	input  logic [7:0]               ram_rdata_b,
	output logic                     empty,
	input  logic                     pop,
	output brm_pkg::res_t            res
);
	import brm_pkg::*;

	dec_t              dec_s2;
	logic              valid_s2;
	logic              byp_we_q;
	reg_idx_t          byp_addr_q;
	logic [7:0]        byp_data_q;
	logic signed [7:0] pc_q;
	logic              stopped_q;
	res_t              res_q;
	logic              res_valid_q;

	logic              fire;
	logic [7:0]        opa;
	logic [7:0]        opb;
	logic              wr;
	logic [7:0]        wdata;
	logic              ov;
	logic [7:0]        ob;
	logic              stop_n;
	logic              jump;
	logic signed [9:0] pc_w;
	logic signed [9:0] sum;
	logic signed [9:0] tgt;
	logic signed [9:0] npc_w;
	logic signed [7:0] npc;

	assign fire  = valid_s2 && (!res_valid_q || pop);
	assign q_pop = q_valid && (!valid_s2 || fire);

	assign ram_re      = q_pop;
	assign ram_raddr_a = q_dout.rx;
	assign ram_raddr_b = q_dout.ry;
	assign ram_we      = fire && wr;
	assign ram_waddr   = dec_s2.rx;
	assign ram_wdata   = wdata;

	// the write retiring in the read cycle is not yet seen by the ram
	assign opa = (byp_we_q && byp_addr_q == dec_s2.rx) ? byp_data_q : ram_rdata_a;
	assign opb = (byp_we_q && byp_addr_q == dec_s2.ry) ? byp_data_q : ram_rdata_b;

	always_comb begin
		wr     = 1'b0;
		wdata  = opa;
		ov     = 1'b0;
		ob     = '0;
		stop_n = stopped_q;
		jump   = 1'b0;
		if (!stopped_q) begin
			case (dec_s2.cls)
				CLS_MOV: begin
					wr    = 1'b1;
					wdata = opb;
				end
				CLS_LDC: begin
					wr    = 1'b1;
					wdata = dec_s2.imm;
				end
				CLS_SHL: begin
					wr    = 1'b1;
					wdata = {opa[6:0], 1'b0};
				end
				CLS_SHR: begin
					wr    = 1'b1;
					wdata = {1'b0, opa[7:1]};
				end
				CLS_ADD: begin
					wr    = 1'b1;
					wdata = opa + opb;
				end
				CLS_SUB: begin
					wr    = 1'b1;
					wdata = opa - opb;
				end
				CLS_XOR: begin
					wr    = 1'b1;
					wdata = opa ^ opb;
				end
				CLS_OR: begin
					wr    = 1'b1;
					wdata = opa | opb;
				end
				CLS_IN: begin
					wr    = 1'b1;
					wdata = dec_s2.imm;
				end
				CLS_OUT: begin
					ov = 1'b1;
					ob = opa;
				end
				CLS_HALT: stop_n = 1'b1;
				CLS_JMP:  jump   = 1'b1;
				default:  wr     = 1'b0;
			endcase
		end
	end

	// jump target wraps back past the program end
	always_comb begin
		pc_w  = {{2{pc_q[7]}}, pc_q};
		sum   = pc_w + {{2{dec_s2.off[7]}}, dec_s2.off};
		tgt   = (sum > PROG_LAST_W) ? sum - WRAP_SUB : sum;
		npc_w = (jump ? tgt : pc_w) + PC_STEP;
		npc   = stopped_q ? pc_q : npc_w[7:0];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dec_s2     <= q_dout;
			byp_addr_q <= ram_waddr;
			byp_data_q <= ram_wdata;
		end
		if (fire) begin
			res_q.next_pc   <= npc;
			res_q.out_valid <= ov;
			res_q.out_byte  <= ob;
			res_q.halted    <= stop_n;
			res_q.pc_fault  <= npc[7] || (npc > PROG_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			byp_we_q    <= 1'b0;
			pc_q        <= '0;
			stopped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s2 <= 1'b1;
				byp_we_q <= ram_we;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				pc_q      <= npc;
				stopped_q <= stop_n;
			end
			if (fire)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
		end
	end

	assign empty = !res_valid_q;
	assign res   = res_q;

endmodule

@@ rtl/byte_register_machine_execute.sv @@
// one instruction per item, one result per item
// throughput: one item per cycle while the result side pops every cycle
// an item passes the decode queue, then the register file read,
// then the execute step into the result register
// reset: program counter 0, machine running, queues empty; register file undefined
module byte_register_machine_execute (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        op,
	input  logic [7:0]        operand,
	input  logic [7:0]        input_byte,
	input  logic              input_at_end,
	output logic              empty,
	input  logic              pop,
	output logic signed [7:0] next_pc,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              halted,
	output logic              pc_fault
);
	import brm_pkg::*;

	logic       q_full;
	logic       q_push;
	dec_t       q_din;
	logic       q_pop;
	dec_t       q_dout;
	logic       q_valid;
	logic       ram_we;
	reg_idx_t   ram_waddr;
	logic [7:0] ram_wdata;
	logic       ram_re;
	reg_idx_t   ram_raddr_a;
	reg_idx_t   ram_raddr_b;
	logic [7:0] ram_rdata_a;
	logic [7:0] ram_rdata_b;
	res_t       res;

	brm_front u_front (
		.push         (push),
		.full         (full),
		.op           (op),
		.operand      (operand),
		.input_byte   (input_byte),
		.input_at_end (input_at_end),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_din        (q_din)
	);

	brm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	brm_ram #(
		.WIDTH (8),
		.DEPTH (NUM_REGS),
		.AW    (REG_W)
	) u_regs (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	brm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_dout      (q_dout),
		.q_pop       (q_pop),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b),
		.empty       (empty),
		.pop         (pop),
		.res         (res)
	);

	assign next_pc   = res.next_pc;
	assign out_valid = res.out_valid;
	assign out_byte  = res.out_byte;
	assign halted    = res.halted;
	assign pc_fault  = res.pc_fault;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	import brm_pkg::*;

	localparam int N_RANDOM    = 530;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 200;

	typedef struct {
		logic [7:0] op;
		logic [7:0] operand;
		logic [7:0] input_byte;
		logic       input_at_end;
		logic       drain;
	} instr_t;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [7:0]        op;
	logic [7:0]        operand;
	logic [7:0]        input_byte;
	logic              input_at_end;
	logic              empty;
	logic              pop;
	logic signed [7:0] next_pc;
	logic              out_valid;
	logic [7:0]        out_byte;
	logic              halted;
	logic              pc_fault;

	byte_register_machine_execute i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.operand      (operand),
		.input_byte   (input_byte),
		.input_at_end (input_at_end),
		.empty        (empty),
		.pop          (pop),
		.next_pc      (next_pc),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.halted       (halted),
		.pc_fault     (pc_fault)
	);

	instr_t     program_q[$];
	res_t       predicted_exec_q[$];
	instr_t     cur_instr;
	int         err_count = 0;
	int         cycle_cnt = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         stall_mode = 0;
	int         stall_left = 0;

	// generator side: registers that hold a value, so no read of an unwritten one is issued
	logic [NUM_REGS-1:0] reg_loaded = '0;

	// predicted machine state
	logic [7:0] mach_regs [NUM_REGS];
	logic [7:0] mach_pc = '0;
	logic       mach_stopped = 1'b0;

	function automatic int jump_dest(int pc, int off);
		if (off > PROG_BYTES - 1)
			pc += off % 16;
		else
			pc += off;
		if (pc > PROG_BYTES - 1)
			pc -= PROG_BYTES + 2;
		return pc;
	endfunction

	function automatic res_t execute_instr(instr_t it);
		res_t r;
		int   pc;
		int   rx;
		int   ry;
		int   npc;
		rx = it.operand[3:0] % NUM_REGS;
		ry = it.operand[7:4] % NUM_REGS;
		pc = $signed(mach_pc);
		r = '0;
		if (!mach_stopped) begin
			case (it.op)
				OPC_MOV:  mach_regs[rx] = mach_regs[ry];
				OPC_LDC:  mach_regs[0] = it.operand;
				OPC_SHL:  mach_regs[rx] = mach_regs[rx] << 1;
				OPC_SHR:  mach_regs[rx] = mach_regs[rx] >> 1;
				OPC_JMP:  pc = jump_dest(pc, int'(it.operand));
				OPC_JEND: if (it.input_at_end) pc = jump_dest(pc, int'($signed(it.operand)));
				OPC_HALT: mach_stopped = 1'b1;
				OPC_ADD:  mach_regs[rx] = mach_regs[rx] + mach_regs[ry];
				OPC_SUB:  mach_regs[rx] = mach_regs[rx] - mach_regs[ry];
				OPC_XOR:  mach_regs[rx] = mach_regs[rx] ^ mach_regs[ry];
				OPC_OR:   mach_regs[rx] = mach_regs[rx] | mach_regs[ry];
				OPC_IN:   mach_regs[rx] = it.input_byte;
				OPC_OUT: begin
					r.out_valid = 1'b1;
					r.out_byte  = mach_regs[rx];
				end
				default: ;
			endcase
			pc += 2;
			mach_pc = pc[7:0];
		end
		npc = $signed(mach_pc);
		r.next_pc  = mach_pc;
		r.halted   = mach_stopped;
		r.pc_fault = (npc < 0) || (npc > PROG_BYTES - 1);
		return r;
	endfunction

	function automatic logic [3:0] loaded_nibble();
		logic [3:0] n;
		n = 4'($urandom_range(0, 15));
		while (!reg_loaded[n % NUM_REGS])
			n = 4'($urandom_range(0, 15));
		return n;
	endfunction

	// keep the random operand but point every register read at a loaded register
	function automatic logic [7:0] legal_operand(logic [7:0] o, logic [7:0] a);
		case (o)
			OPC_MOV: a[7:4] = loaded_nibble();
			OPC_SHL, OPC_SHR, OPC_OUT: a[3:0] = loaded_nibble();
			OPC_ADD, OPC_SUB, OPC_XOR, OPC_OR: begin
				a[3:0] = loaded_nibble();
				a[7:4] = loaded_nibble();
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic add_item(logic [7:0] o, logic [7:0] a, logic [7:0] b, logic e, logic d);
		instr_t it;
		it.op           = o;
		it.operand      = a;
		it.input_byte   = b;
		it.input_at_end = e;
		it.drain        = d;
		program_q.push_back(it);
		if (o == OPC_MOV || o == OPC_IN)
			reg_loaded[a[3:0] % NUM_REGS] = 1'b1;
		else if (o == OPC_LDC)
			reg_loaded[0] = 1'b1;
	endtask

	task automatic add_random_item(logic d);
		int         pick;
		logic [7:0] o;
		pick = $urandom_range(0, 99);
		if (pick < 14)
			o = OPC_IN;
		else if (pick < 20)
			o = OPC_LDC;
		else if (pick < 28)
			o = OPC_MOV;
		else if (pick < 36)
			o = OPC_JMP;
		else if (pick < 46)
			o = OPC_JEND;
		else if (pick < 51)
			o = OPC_SHL;
		else if (pick < 56)
			o = OPC_SHR;
		else if (pick < 61)
			o = OPC_ADD;
		else if (pick < 66)
			o = OPC_SUB;
		else if (pick < 71)
			o = OPC_XOR;
		else if (pick < 76)
			o = OPC_OR;
		else if (pick < 88)
			o = OPC_OUT;
		else begin
			// any opcode byte, unused ones included; halt is kept for the end
			o = 8'($urandom_range(0, 255));
			if (o == OPC_HALT)
				o = 8'hFF;
		end
		add_item(o, legal_operand(o, 8'($urandom_range(0, 255))), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), d);
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		op           = '0;
		operand      = '0;
		input_byte   = '0;
		input_at_end = 1'b0;
		for (int k = 0; k < NUM_REGS; k++)
			mach_regs[k] = '0;

		// directed: extreme values, every operation except halt, jump wrap cases
		add_item(OPC_LDC, 8'hFF, 8'h00, 1'b0, 1'b0);
		add_item(OPC_IN, 8'h0F, 8'h00, 1'b0, 1'b0);
		add_item(OPC_IN, 8'h01, 8'h80, 1'b0, 1'b0);
		add_item(OPC_IN, 8'hF2, 8'h7F, 1'b1, 1'b0);
		add_item(OPC_MOV, 8'h03, 8'h55, 1'b0, 1'b0);
		add_item(OPC_MOV, 8'hFE, 8'hAA, 1'b1, 1'b0);
		add_item(OPC_SHL, 8'hF0, 8'h00, 1'b0, 1'b0);
		add_item(OPC_SHR, 8'h01, 8'h00, 1'b0, 1'b0);
		add_item(OPC_ADD, 8'h30, 8'h00, 1'b0, 1'b0);
		add_item(OPC_SUB, 8'h0F, 8'h00, 1'b0, 1'b0);
		add_item(OPC_XOR, 8'h12, 8'h00, 1'b0, 1'b0);
		add_item(OPC_OR, 8'hE3, 8'h00, 1'b0, 1'b0);
		add_item(OPC_OUT, 8'h00, 8'h00, 1'b0, 1'b0);
		add_item(OPC_OUT, 8'hFF, 8'hFF, 1'b1, 1'b0);
		add_item(OPC_JMP, 8'h1F, 8'h00, 1'b0, 1'b0);
		add_item(OPC_JMP, 8'hFF, 8'h00, 1'b0, 1'b0);
		add_item(OPC_JMP, 8'h20, 8'h00, 1'b0, 1'b0);
		// conditional jump with input still running does not jump
		add_item(OPC_JEND, 8'h80, 8'h00, 1'b0, 1'b0);
		add_item(OPC_JEND, 8'h80, 8'h00, 1'b1, 1'b0);
		add_item(OPC_JEND, 8'h7F, 8'h00, 1'b1, 1'b0);
		add_item(OPC_JEND, 8'h00, 8'h00, 1'b1, 1'b0);
		add_item(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
		add_item(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
		add_item(8'h08, 8'h5A, 8'hA5, 1'b0, 1'b0);

		for (int k = 0; k < N_RANDOM; k++)
			add_random_item(k == N_RANDOM / 3 || k == 2 * N_RANDOM / 3);

		// halt last: everything after it is ignored by the machine
		add_item(OPC_HALT, 8'($urandom_range(0, 255)), 8'h00, 1'b0, 1'b0);
		add_item(OPC_OUT, 8'h0F, 8'h00, 1'b0, 1'b0);
		add_item(OPC_JMP, 8'h10, 8'h00, 1'b1, 1'b0);
		add_item(OPC_HALT, 8'h00, 8'h00, 1'b0, 1'b0);
		for (int k = 0; k < 4; k++)
			add_random_item(1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// look between edges so the driver and monitor updates have settled
		while (program_q.size() != 0 || push || predicted_exec_q.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		if (err_count == 0)
			$display("byte_register_machine_execute verification clean");
		else
			$display("byte_register_machine_execute verification failed");
		$finish;
	end

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				predicted_exec_q.push_back(execute_instr(cur_instr));
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (program_q.size() == 0 ||
					(program_q[0].drain && predicted_exec_q.size() != 0)) begin
					push <= 1'b0;
				end else begin
					cur_instr = program_q.pop_front();
					push         <= 1'b1;
					op           <= cur_instr.op;
					operand      <= cur_instr.operand;
					input_byte   <= cur_instr.input_byte;
					input_at_end <= cur_instr.input_at_end;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (predicted_exec_q.size() == 0) begin
					err_count++;
					$error("result with no item waiting: next_pc %0h", next_pc);
				end else begin
					want = predicted_exec_q.pop_front();
					check_field("next_pc", want.next_pc, next_pc);
					check_field("out_valid", 8'(want.out_valid), 8'(out_valid));
					check_field("out_byte", want.out_byte, out_byte);
					check_field("halted", 8'(want.halted), 8'(halted));
					check_field("pc_fault", 8'(want.pc_fault), 8'(pc_fault));
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 120);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0:       pop <= 1'b1;
				1:       pop <= ($urandom_range(0, 1) == 0);
				2:       pop <= ($urandom_range(0, 4) == 0);
				default: pop <= (stall_left % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("byte_register_machine_execute verification failed");
			$finish;
		end
	end

endmodule

@@ sim.f @@
rtl/brm_pkg.sv
rtl/brm_ram.sv
rtl/brm_queue.sv
rtl/brm_front.sv
rtl/brm_back.sv
rtl/byte_register_machine_execute.sv
verif/tb_top.sv
